// ===== sv/tmcg_pkg.sv =====
// Shared types and constants of the text-mode character generator.
`timescale 1ns / 1ps

package tmcg_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FONT  = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  // Font store: 256 glyphs of 8 rows.
  localparam int FONT_AW = 11;

  // Cell word holding the background colour, and the first text cell.
  localparam int BG_WORD    = 'h2F;
  localparam int TEXT_START = 'h30;

  localparam logic [7:0] RED_MASK = 8'b1110_0000;
  localparam logic [7:0] GRN_MASK = 8'b0001_1100;
  localparam logic [7:0] BLU_MASK = 8'b0000_0011;

  typedef struct packed {
    logic [8:0] x;
    logic [8:0] y;
    logic       frame_end;
  } scan_pos_t;

  typedef struct packed {
    req_t       kind;
    logic       hit;
    scan_pos_t  pos;
    logic [7:0] bg;
  } stage_info_t;

endpackage

// ===== sv/tmcg_scan.sv =====
// Raster position counter and text cell address of the current pixel.
`timescale 1ns / 1ps

module tmcg_scan #(
  parameter int TEXT_COLS  = 50,
  parameter int TEXT_ROWS  = 40,
  parameter int CELL_WORDS = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  output tmcg_pkg::scan_pos_t           pos,
  output logic [$clog2(CELL_WORDS)-1:0] cell_idx
);

  localparam int AW     = $clog2(CELL_WORDS);
  localparam int IW     = AW + 1;
  localparam int WIDTH  = TEXT_COLS * 8;
  localparam int HEIGHT = TEXT_ROWS * 8;

  logic [8:0]    col_r, col_nxt;
  logic [8:0]    row_r, row_nxt;
  logic          last_col, last_row;
  logic [IW-1:0] lin_idx;
  logic [IW-1:0] wrap_idx;

  assign last_col = (col_r == 9'(WIDTH - 1));
  assign last_row = (row_r == 9'(HEIGHT - 1));

  always_comb begin
    col_nxt = col_r + 9'd1;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Cell = col/8 + (row/8)*cols + start; stays below twice the memory size.
  assign lin_idx = IW'(row_r[8:3]) * IW'(TEXT_COLS) + IW'(col_r[8:3])
                 + IW'(tmcg_pkg::TEXT_START);
  assign wrap_idx = (lin_idx >= IW'(CELL_WORDS)) ? lin_idx - IW'(CELL_WORDS) : lin_idx;
  assign cell_idx = wrap_idx[AW-1:0];

  assign pos.x         = col_r;
  assign pos.y         = row_r;
  assign pos.frame_end = last_col && last_row;

endmodule

// ===== sv/text_mode_character_generator.sv =====
// Top level of the text-mode character generator: cell memory, font store, pixel pipe.
`timescale 1ns / 1ps

// Text-mode character generator, 8x8 glyphs.
// One request channel (in_*) carries bus reads, bus writes, font byte writes
// and pixel ticks; one result channel (out_*) returns exactly one result per
// request, in request order. Bus accesses hit the cell memory when the address
// falls in the window at WINDOW_BASE; a pixel tick scans the next pixel of the
// TEXT_COLS x TEXT_ROWS cell screen and returns it as RGB332 plus 8-bit channels.
// Throughput: one request per cycle while in_stall is low. Three register stages
// (cell memory read, font read that depends on the glyph code, colour selection
// into the output register); a result stays in the output register until taken.
// Writes land at accept and reads issue at accept, so later requests always see
// earlier writes without forwarding; word 0x2F's colour byte is shadowed in a
// register so the pixel path needs only one cell memory read port.
// Reset: synchronous, active low. After reset a clearing pass zeroes the cell
// memory one word per cycle, with in_stall held high. The font store is not
// cleared. When the receiver stalls a waiting result, the whole pipe holds and
// in_stall rises in the same cycle; nothing is dropped.

module text_mode_character_generator #(
  parameter int TEXT_COLS   = 50,
  parameter int TEXT_ROWS   = 40,
  parameter int CELL_WORDS  = 2048,
  parameter int WINDOW_BASE = 55296
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_address,
  input  logic [15:0] in_write_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_read_data,
  output logic        out_read_hit,
  output logic        out_pixel_valid,
  output logic [8:0]  out_pixel_x,
  output logic [8:0]  out_pixel_y,
  output logic [7:0]  out_pixel_value,
  output logic [7:0]  out_pixel_red,
  output logic [7:0]  out_pixel_green,
  output logic [7:0]  out_pixel_blue,
  output logic        out_frame_end
);

  localparam int AW = $clog2(CELL_WORDS);
  localparam int FW = tmcg_pkg::FONT_AW;

  // ---------------------------------------------------------------- control
  logic               adv;        // whole pipe moves one stage
  logic               acc;        // request taken this cycle
  tmcg_pkg::req_t     kind;
  logic               in_win;
  logic [15:0]        win_diff;
  logic [AW-1:0]      win_off;

  logic               clr_r;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [7:0]         bg_r, bg_nxt;

  tmcg_pkg::scan_pos_t scan_pos;
  logic [AW-1:0]       scan_idx;

  // Hold everything while a finished result waits on a stalled receiver.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = clr_r || !adv;
  assign acc      = in_valid && !in_stall;
  assign kind     = tmcg_pkg::req_t'(in_req_type);

  // Window check in 17 bits so a window touching the top of the map works.
  assign in_win   = ({1'b0, in_address} >= 17'(WINDOW_BASE)) &&
                    ({1'b0, in_address} <  17'(WINDOW_BASE + CELL_WORDS));
  assign win_diff = in_address - 16'(WINDOW_BASE);
  assign win_off  = win_diff[AW-1:0];

  tmcg_scan #(
    .TEXT_COLS  (TEXT_COLS),
    .TEXT_ROWS  (TEXT_ROWS),
    .CELL_WORDS (CELL_WORDS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (acc && kind == tmcg_pkg::REQ_TICK),
    .pos      (scan_pos),
    .cell_idx (scan_idx)
  );

  // ---------------------------------------------------------------- clearing pass
  assign clr_cnt_nxt = clr_cnt_r + AW'(1);

  // Shadow of the background byte (high byte of word 0x2F).
  always_comb begin
    bg_nxt = bg_r;
    if (acc && kind == tmcg_pkg::REQ_WRITE && in_win &&
        win_off == AW'(tmcg_pkg::BG_WORD)) begin
      bg_nxt = in_write_data[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      bg_r      <= '0;
    end else begin
      bg_r <= bg_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_nxt;
        if (clr_cnt_r == AW'(CELL_WORDS - 1)) begin
          clr_r <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- cell memory
  logic [15:0]   cell_mem [CELL_WORDS];
  logic [15:0]   cell_q_r;
  logic [AW-1:0] cell_raddr;
  logic [AW-1:0] cell_waddr;
  logic [15:0]   cell_wdata;
  logic          cell_we;

  assign cell_raddr = (kind == tmcg_pkg::REQ_TICK) ? scan_idx : win_off;
  assign cell_we    = clr_r || (acc && kind == tmcg_pkg::REQ_WRITE && in_win);
  assign cell_waddr = clr_r ? clr_cnt_r : win_off;
  assign cell_wdata = clr_r ? 16'd0 : in_write_data;

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_q_r <= cell_mem[cell_raddr];
    end
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
  end

  // ---------------------------------------------------------------- stage 1
  tmcg_pkg::stage_info_t s1_info_r, s1_info_nxt;
  logic                  s1_vld_r;

  always_comb begin
    s1_info_nxt.kind = kind;
    s1_info_nxt.hit  = in_win && (kind == tmcg_pkg::REQ_READ || kind == tmcg_pkg::REQ_WRITE);
    s1_info_nxt.pos  = scan_pos;
    s1_info_nxt.bg   = bg_r;
  end

  // ---------------------------------------------------------------- font store
  logic [7:0]    font_mem [2**FW];
  logic [7:0]    font_q_r;
  logic [FW-1:0] font_raddr;
  logic          font_we;

  // Glyph row address: code * 8 + pixel row within the cell.
  assign font_raddr = {cell_q_r[7:0], s1_info_r.pos.y[2:0]};
  assign font_we    = acc && kind == tmcg_pkg::REQ_FONT && in_address[15:FW] == '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      font_q_r <= font_mem[font_raddr];
    end
    if (font_we) begin
      font_mem[in_address[FW-1:0]] <= in_write_data[7:0];
    end
  end

  // ---------------------------------------------------------------- stage 2
  tmcg_pkg::stage_info_t s2_info_r;
  logic                  s2_vld_r;
  logic [15:0]           s2_cell_r;

  // ---------------------------------------------------------------- result stage
  logic        out_valid_r;
  logic [15:0] rd_data_nxt, rd_data_r;
  logic        hit_nxt, hit_r;
  logic        pix_vld_nxt, pix_vld_r;
  logic [8:0]  px_nxt, px_r;
  logic [8:0]  py_nxt, py_r;
  logic [7:0]  pv_nxt, pv_r;
  logic        fend_nxt, fend_r;
  logic        glyph_bit;

  // Bit 7 of a glyph row is the leftmost pixel.
  assign glyph_bit = font_q_r[3'd7 - s2_info_r.pos.x[2:0]];

  always_comb begin
    rd_data_nxt = '0;
    hit_nxt     = s2_info_r.hit;
    pix_vld_nxt = 1'b0;
    px_nxt      = '0;
    py_nxt      = '0;
    pv_nxt      = '0;
    fend_nxt    = 1'b0;
    unique case (s2_info_r.kind)
      tmcg_pkg::REQ_READ: begin
        if (s2_info_r.hit) begin
          rd_data_nxt = s2_cell_r;
        end
      end
      tmcg_pkg::REQ_WRITE: begin
      end
      tmcg_pkg::REQ_FONT: begin
      end
      tmcg_pkg::REQ_TICK: begin
        pix_vld_nxt = 1'b1;
        px_nxt      = s2_info_r.pos.x;
        py_nxt      = s2_info_r.pos.y;
        pv_nxt      = glyph_bit ? s2_cell_r[15:8] : s2_info_r.bg;
        fend_nxt    = s2_info_r.pos.frame_end;
      end
      default: begin
      end
    endcase
  end

  // Valid bits of the pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= acc;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r;
    end
  end

  // Payload of the pipe; advances with the valid bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_info_r <= s1_info_nxt;
      s2_info_r <= s1_info_r;
      s2_cell_r <= cell_q_r;
      rd_data_r <= rd_data_nxt;
      hit_r     <= hit_nxt;
      pix_vld_r <= pix_vld_nxt;
      px_r      <= px_nxt;
      py_r      <= py_nxt;
      pv_r      <= pv_nxt;
      fend_r    <= fend_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = rd_data_r;
  assign out_read_hit    = hit_r;
  assign out_pixel_valid = pix_vld_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_value = pv_r;
  // Expand RGB332 to 8-bit channels, left aligned.
  assign out_pixel_red   = pv_r & tmcg_pkg::RED_MASK;
  assign out_pixel_green = (pv_r & tmcg_pkg::GRN_MASK) << 3;
  assign out_pixel_blue  = (pv_r & tmcg_pkg::BLU_MASK) << 6;
  assign out_frame_end   = fend_r;

endmodule

// ===== sv/tmcg_checker.sv =====
// Port-level checks of the text-mode character generator, bound to the top level.
`timescale 1ns / 1ps

module tmcg_checker #(
  parameter int TEXT_COLS = 50,
  parameter int TEXT_ROWS = 40
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_read_hit,
  input logic        out_pixel_valid,
  input logic [8:0]  out_pixel_x,
  input logic [8:0]  out_pixel_y,
  input logic [7:0]  out_pixel_value,
  input logic        out_frame_end
);

  // The clearing pass blocks requests right after reset.
  a_clear_blocks: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request side open right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hit_vs_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_read_hit && out_pixel_valid))
    else $error("result is both a bus hit and a pixel");

  a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |->
      out_pixel_valid && out_pixel_x == 9'(TEXT_COLS * 8 - 1) &&
      out_pixel_y == 9'(TEXT_ROWS * 8 - 1))
    else $error("frame end away from the last pixel");

  a_quiet_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_valid |->
      out_pixel_value == 8'd0 && !out_frame_end && out_pixel_x == 9'd0)
    else $error("pixel fields set on a bus or font result");

endmodule

bind text_mode_character_generator tmcg_checker #(
  .TEXT_COLS (TEXT_COLS),
  .TEXT_ROWS (TEXT_ROWS)
) u_tmcg_checker (.*);
